[src/mts_pkg.sv]
// Package for the min-tracking stack: sizes, codes and the types passed
// between the top level and its row of stack cells. No dependencies.
package mts_pkg;

  localparam int DEPTH      = 256;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  // Operation codes carried by in_mode
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One stack entry: its value and the minimum of it and all entries below
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic signed [VALUE_BITS-1:0] run_min;
  } entry_t;

  // Shift command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

[src/min_tracking_stack.sv]
// Top level of the min-tracking stack: count, push/pop control, result
// register and the row of mts_cell instances. Uses mts_pkg and mts_cell.
//
//  channel | direction | ports
//  --------+-----------+-----------------------------------------------------
//  in      | input     | in_valid, in_ready, in_mode, in_push_value
//  out     | output    | out_valid, out_ready, out_popped_value, out_top_value,
//          |           | out_min_value, out_entry_count, out_status
//
// One item per cycle: each item is accepted and its result registered in the
// same edge, so the result appears in the next cycle. The stack is a shift row
// of cells whose cell 0 is always the top, so top and minimum are read from
// fixed registers. Reset (rst_n low, synchronous) empties the stack and drops
// any waiting result. While out_ready is low with a result waiting, in_ready
// is low and the stack holds.
module min_tracking_stack (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_mode,
  input  logic signed [mts_pkg::VALUE_BITS-1:0] in_push_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mts_pkg::VALUE_BITS-1:0] out_popped_value,
  output logic signed [mts_pkg::VALUE_BITS-1:0] out_top_value,
  output logic signed [mts_pkg::VALUE_BITS-1:0] out_min_value,
  output logic        [mts_pkg::COUNT_BITS-1:0] out_entry_count,
  output logic        [1:0]                     out_status
);

  localparam logic [mts_pkg::COUNT_BITS-1:0] COUNT_FULL =
    mts_pkg::COUNT_BITS'(mts_pkg::DEPTH);
  localparam logic [mts_pkg::COUNT_BITS-1:0] COUNT_ONE =
    mts_pkg::COUNT_BITS'(1);

  logic [mts_pkg::COUNT_BITS-1:0] count_r;
  logic [mts_pkg::COUNT_BITS-1:0] count_nxt;

  logic                                  out_valid_r;
  logic                                  out_valid_nxt;
  logic signed [mts_pkg::VALUE_BITS-1:0] popped_r;
  logic signed [mts_pkg::VALUE_BITS-1:0] popped_nxt;
  logic signed [mts_pkg::VALUE_BITS-1:0] top_r;
  logic signed [mts_pkg::VALUE_BITS-1:0] top_nxt;
  logic signed [mts_pkg::VALUE_BITS-1:0] min_r;
  logic signed [mts_pkg::VALUE_BITS-1:0] min_nxt;
  mts_pkg::status_t                      status_r;
  mts_pkg::status_t                      status_nxt;

  mts_pkg::entry_t chain [mts_pkg::DEPTH];
  mts_pkg::entry_t new_entry;
  mts_pkg::shift_t shift;

  logic accept;
  logic is_full;
  logic is_empty;

  assign is_full  = (count_r == COUNT_FULL);
  assign is_empty = (count_r == '0);
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Decide the shift: refused operations leave the row untouched
  always_comb begin
    shift.push = accept && (in_mode == mts_pkg::MODE_PUSH) && !is_full;
    shift.pop  = accept && (in_mode == mts_pkg::MODE_POP) && !is_empty;
  end

  // Build the entry to push: keep the old minimum unless the new value is lower
  always_comb begin
    new_entry.value   = in_push_value;
    new_entry.run_min = in_push_value;
    if (!is_empty && !(in_push_value < chain[0].run_min)) begin
      new_entry.run_min = chain[0].run_min;
    end
  end

  // Row of cells, cell 0 holding the top of the stack
  for (genvar i = 0; i < mts_pkg::DEPTH; i++) begin : g_cell
    mts_pkg::entry_t above;
    mts_pkg::entry_t below;
    if (i == 0) begin : g_first
      assign above = new_entry;
    end else begin : g_inner_above
      assign above = chain[i-1];
    end
    if (i == mts_pkg::DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner_below
      assign below = chain[i+1];
    end
    mts_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .above (above),
      .below (below),
      .held  (chain[i])
    );
  end

  // Work out the count and the result of the accepted item
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    popped_nxt    = popped_r;
    top_nxt       = top_r;
    min_nxt       = min_r;
    status_nxt    = status_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      popped_nxt    = '0;
      status_nxt    = mts_pkg::ST_DONE;
      if (is_empty) begin
        top_nxt = '0;
        min_nxt = '0;
      end else begin
        top_nxt = chain[0].value;
        min_nxt = chain[0].run_min;
      end
      if (shift.push) begin
        count_nxt = count_r + COUNT_ONE;
        top_nxt   = new_entry.value;
        min_nxt   = new_entry.run_min;
      end else if (shift.pop) begin
        count_nxt  = count_r - COUNT_ONE;
        popped_nxt = chain[0].value;
        if (count_r == COUNT_ONE) begin
          top_nxt = '0;
          min_nxt = '0;
        end else begin
          top_nxt = chain[1].value;
          min_nxt = chain[1].run_min;
        end
      end else if (in_mode == mts_pkg::MODE_PUSH) begin
        status_nxt = mts_pkg::ST_FULL;
      end else begin
        status_nxt = mts_pkg::ST_EMPTY;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    popped_r <= popped_nxt;
    top_r    <= top_nxt;
    min_r    <= min_nxt;
    status_r <= status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = popped_r;
  assign out_top_value    = top_r;
  assign out_min_value    = min_r;
  assign out_entry_count  = count_r;
  assign out_status       = status_r;

endmodule

[src/mts_cell.sv]
// One cell of the stack row: holds a single entry and takes its neighbour's
// entry on a push (from above) or a pop (from below). Uses mts_pkg.
module mts_cell (
  input  logic            clk,
  input  mts_pkg::shift_t shift,
  input  mts_pkg::entry_t above,
  input  mts_pkg::entry_t below,
  output mts_pkg::entry_t held
);

  mts_pkg::entry_t entry_r;
  mts_pkg::entry_t entry_nxt;

  // Take the upper neighbour on push, the lower one on pop, else hold
  always_comb begin
    entry_nxt = entry_r;
    if (shift.push) begin
      entry_nxt = above;
    end else if (shift.pop) begin
      entry_nxt = below;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign held = entry_r;

endmodule

[dv/min_tracking_stack_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for min_tracking_stack: drives push/pop items, predicts each
// result from its own stack model and compares field by field. Uses mts_pkg.
module min_tracking_stack_test;

  typedef struct {
    logic signed [mts_pkg::VALUE_BITS-1:0] popped;
    logic signed [mts_pkg::VALUE_BITS-1:0] top;
    logic signed [mts_pkg::VALUE_BITS-1:0] minimum;
    logic        [mts_pkg::COUNT_BITS-1:0] count;
    mts_pkg::status_t                      status;
  } stack_result_t;

  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic                                  in_mode = mts_pkg::MODE_PUSH;
  logic signed [mts_pkg::VALUE_BITS-1:0] in_push_value = '0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic signed [mts_pkg::VALUE_BITS-1:0] out_popped_value;
  logic signed [mts_pkg::VALUE_BITS-1:0] out_top_value;
  logic signed [mts_pkg::VALUE_BITS-1:0] out_min_value;
  logic        [mts_pkg::COUNT_BITS-1:0] out_entry_count;
  logic        [1:0]                     out_status;

  // Shadow stack: values, running minima and fill level
  logic signed [mts_pkg::VALUE_BITS-1:0] shadow_values [mts_pkg::DEPTH];
  logic signed [mts_pkg::VALUE_BITS-1:0] shadow_mins [mts_pkg::DEPTH];
  int                                    shadow_count = 0;

  stack_result_t pending_results [$];
  int            error_count = 0;
  bit            no_idle = 1'b0;
  int            hold_req_id = 0;
  int            hold_ack_id = 0;
  int            hold_cycles = 0;

  min_tracking_stack dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (out_popped_value),
    .out_top_value    (out_top_value),
    .out_min_value    (out_min_value),
    .out_entry_count  (out_entry_count),
    .out_status       (out_status)
  );

  always #5 clk = ~clk;

  // Apply one operation to the shadow stack and return the result it should give
  function automatic stack_result_t apply_stack_op(
      logic op_mode, logic signed [mts_pkg::VALUE_BITS-1:0] value);
    stack_result_t r;
    logic signed [mts_pkg::VALUE_BITS-1:0] new_min;
    r.popped  = '0;
    r.top     = '0;
    r.minimum = '0;
    r.status  = mts_pkg::ST_DONE;
    if (op_mode == mts_pkg::MODE_PUSH) begin
      if (shadow_count >= mts_pkg::DEPTH) begin
        r.status = mts_pkg::ST_FULL;
      end else begin
        new_min = value;
        // keep the held minimum on a tie
        if (shadow_count > 0 && !(value < shadow_mins[shadow_count-1]))
          new_min = shadow_mins[shadow_count-1];
        shadow_values[shadow_count] = value;
        shadow_mins[shadow_count]   = new_min;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = mts_pkg::ST_EMPTY;
      end else begin
        shadow_count--;
        r.popped = shadow_values[shadow_count];
      end
    end
    if (shadow_count > 0) begin
      r.top     = shadow_values[shadow_count-1];
      r.minimum = shadow_mins[shadow_count-1];
    end
    r.count = mts_pkg::COUNT_BITS'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [mts_pkg::VALUE_BITS-1:0] got,
                                 logic [mts_pkg::VALUE_BITS-1:0] want);
    $display("ERROR %0t ns: %s got %h expected %h", $time, field, got, want);
    error_count++;
  endtask

  // Offer one item, idling first at random, and log its expected result once accepted
  task automatic send_item(logic op_mode, logic signed [mts_pkg::VALUE_BITS-1:0] value);
    if (!no_idle && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= op_mode;
    in_push_value <= value;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_stack_op(op_mode, value));
  endtask

  // Lower valid and wait until every expected result has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [mts_pkg::VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 9)) inside
      [0:4]:   return $urandom;
      [5:6]:   return $signed(mts_pkg::VALUE_BITS'($urandom_range(0, 15))) - 8;
      7:       return {1'b0, {(mts_pkg::VALUE_BITS-1){1'b1}}};
      8:       return {1'b1, {(mts_pkg::VALUE_BITS-1){1'b0}}};
      default: return $urandom_range(0, 1) ? '0 : '1;
    endcase
  endfunction

  // Receiver: random stalls, quiet stretches and requested long hold-offs
  always @(posedge clk) begin
    if (hold_req_id != hold_ack_id) begin
      hold_ack_id = hold_req_id;
      hold_cycles = 80;
    end
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 18);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    stack_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("ERROR %0t ns: result with nothing expected", $time);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_popped_value !== want.popped)
          report_mismatch("popped_value", out_popped_value, want.popped);
        if (out_top_value !== want.top)
          report_mismatch("top_value", out_top_value, want.top);
        if (out_min_value !== want.minimum)
          report_mismatch("min_value", out_min_value, want.minimum);
        if (out_entry_count !== want.count)
          report_mismatch("entry_count", mts_pkg::VALUE_BITS'(out_entry_count),
                          mts_pkg::VALUE_BITS'(want.count));
        if (out_status !== want.status)
          report_mismatch("status", mts_pkg::VALUE_BITS'(out_status),
                          mts_pkg::VALUE_BITS'(want.status));
      end
    end
  end

  // Extremes, ties, refused pops and pop with a payload that must be ignored
  task automatic test_directed();
    send_item(mts_pkg::MODE_POP, $urandom);
    send_item(mts_pkg::MODE_PUSH, {1'b0, {(mts_pkg::VALUE_BITS-1){1'b1}}});
    send_item(mts_pkg::MODE_PUSH, {1'b1, {(mts_pkg::VALUE_BITS-1){1'b0}}});
    send_item(mts_pkg::MODE_PUSH, {1'b0, {(mts_pkg::VALUE_BITS-1){1'b1}}});
    send_item(mts_pkg::MODE_PUSH, {1'b1, {(mts_pkg::VALUE_BITS-1){1'b0}}});
    repeat (5) send_item(mts_pkg::MODE_POP, $urandom);
    send_item(mts_pkg::MODE_PUSH, '1);
    send_item(mts_pkg::MODE_PUSH, '0);
    send_item(mts_pkg::MODE_PUSH, 1);
    send_item(mts_pkg::MODE_PUSH, '1);
    send_item(mts_pkg::MODE_PUSH, 32'h5555_5555);
    send_item(mts_pkg::MODE_PUSH, 32'haaaa_aaaa);
    repeat (7) send_item(mts_pkg::MODE_POP, '1);
  endtask

  // Fill to the limit, try past it, then empty and try past that
  task automatic test_full_and_empty();
    while (shadow_count < mts_pkg::DEPTH) send_item(mts_pkg::MODE_PUSH, pick_value());
    repeat (3) send_item(mts_pkg::MODE_PUSH, pick_value());
    while (shadow_count > 0) send_item(mts_pkg::MODE_POP, $urandom);
    repeat (2) send_item(mts_pkg::MODE_POP, $urandom);
  endtask

  // Hold the receiver off while items keep coming, then pause until drained
  task automatic test_backpressure();
    hold_req_id++;
    repeat (30)
      send_item($urandom_range(0, 2) == 0 ? mts_pkg::MODE_POP : mts_pkg::MODE_PUSH,
                pick_value());
    wait_drained();
    repeat ($urandom_range(2, 6)) @(posedge clk);
    repeat (10) send_item(1'($urandom_range(0, 1)), pick_value());
  endtask

  // Random walk with push bias varied per phase so the fill level sweeps the range
  task automatic test_random(int items);
    int sent;
    int push_pct;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 3))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      no_idle = (sent >= items / 2 && sent < items / 2 + 200);
      repeat (40) begin
        send_item(($urandom_range(0, 99) < push_pct) ? mts_pkg::MODE_PUSH
                                                     : mts_pkg::MODE_POP,
                  pick_value());
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_and_empty();
    test_backpressure();
    test_random(1260);
    wait_drained();
    repeat (5) @(posedge clk);
    if (error_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
